@@ hdl/elrr_pkg.sv @@
// Shared types and constants for the event latency record ring.
// No dependencies.
package elrr_pkg;
  localparam int RING_DEPTH = 32;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int NUM_CNT = 11;

  localparam logic [3:0] OP_ALLOC = 4'd0;
  localparam logic [3:0] OP_SET12 = 4'd1;
  localparam logic [3:0] OP_SET3 = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd3;
  localparam logic [3:0] OP_DRISR = 4'd4;
  localparam logic [3:0] OP_DRTX = 4'd5;
  localparam logic [3:0] OP_TXERR = 4'd6;
  localparam logic [3:0] OP_TMO = 4'd7;
  localparam logic [3:0] OP_CRC = 4'd8;
  localparam logic [3:0] OP_TDROP = 4'd9;
  localparam logic [3:0] OP_TFAIL = 4'd10;
  localparam logic [3:0] OP_READ = 4'd11;
  localparam logic [3:0] OP_DUMP = 4'd12;
  localparam logic [3:0] OP_RESET = 4'd13;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_OK = 3'd1;
  localparam logic [2:0] ST_LATE = 3'd2;
  localparam logic [2:0] ST_DROP = 3'd3;
  localparam logic [2:0] ST_TXERR = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  localparam logic [3:0] CNT_OVF = 4'd0;
  localparam logic [3:0] CNT_MIS = 4'd1;
  localparam logic [3:0] CNT_LATE = 4'd2;
  localparam logic [3:0] CNT_SUCC = 4'd3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] slot_index;
    logic [15:0] evt_tag;
    logic [7:0]  scen_tag;
    logic [31:0] stamp_a;
    logic [31:0] stamp_b;
    logic [15:0] cursor;
    logic [3:0]  counter_select;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic [15:0] rec_evt_tag;
    logic [7:0]  rec_scen_tag;
    logic [31:0] rec_t0;
    logic [31:0] rec_t1;
    logic [31:0] rec_t2;
    logic [31:0] rec_t3;
    logic [31:0] rec_t4;
    logic [31:0] rec_abs_ms;
    logic [2:0]  rec_status;
    logic [3:0]  rec_stamp_mask;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input word and issue memory reads
    logic execute;  // update state and form result
  } dp_cmd_t;
endpackage

@@ hdl/elrr_ctrl.sv @@
// Controller for the record ring: sequences load, execute and result handoff.
// Depends on elrr_pkg.
module elrr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output elrr_pkg::dp_cmd_t cmd
);
  import elrr_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;
  state_t state;
  logic exec_go;

  // Execute once the result register is free or is being emptied this cycle
  assign in_ready = (state == S_IDLE) && !rst;
  assign exec_go = (state == S_EXEC) && (!out_valid || out_ready);
  assign cmd.load = in_valid && in_ready;
  assign cmd.execute = exec_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: if (exec_go) state <= S_IDLE;
      endcase
      if (exec_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

@@ hdl/elrr_dpath.sv @@
// Datapath for the record ring: record memories, flags, counters, result.
// Depends on elrr_pkg.
module elrr_dpath (
  input  logic clk,
  input  logic rst,
  input  elrr_pkg::dp_cmd_t cmd,
  input  elrr_pkg::in_word_t in_word,
  input  logic [31:0] deadline_ticks,
  output elrr_pkg::out_word_t out_word
);
  import elrr_pkg::*;

  logic [23:0] ids_mem [RING_DEPTH];
  logic [63:0] st0_mem [RING_DEPTH];
  logic [63:0] st1_mem [RING_DEPTH];
  logic [63:0] st2_mem [RING_DEPTH];
  logic [7:0]  flags [RING_DEPTH];
  logic [31:0] counters [NUM_CNT];
  logic [31:0] total_allocated;

  in_word_t    iw;
  logic [23:0] rd_ids;
  logic [63:0] rd_st0, rd_st1, rd_st2;
  logic [SLOT_W-1:0] addr, rd_addr;

  // Address decode at load: alloc, dump or named slot
  logic wrapped;
  logic [31:0] count;
  logic [SLOT_W-1:0] start;
  assign wrapped = total_allocated > 32'(RING_DEPTH);
  assign count = wrapped ? 32'(RING_DEPTH) : total_allocated;
  assign start = wrapped ? total_allocated[SLOT_W-1:0] : '0;

  always_comb begin
    if (in_word.mode == OP_ALLOC) addr = total_allocated[SLOT_W-1:0];
    else if (in_word.mode == OP_DUMP) addr = start + in_word.cursor[SLOT_W-1:0];
    else addr = in_word.slot_index[SLOT_W-1:0];
  end

  logic in_range, id_ok, slot_ok;
  logic [7:0] f;
  assign f = flags[rd_addr];
  assign in_range = (iw.slot_index < 16'(RING_DEPTH));
  assign id_ok = f[7] && (rd_ids[15:0] == iw.evt_tag);
  assign slot_ok = in_range && id_ok;

  logic [31:0] dt;
  assign dt = iw.stamp_a - rd_st0[31:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      iw <= in_word;
      rd_addr <= addr;
      rd_ids <= ids_mem[addr];
      rd_st0 <= st0_mem[addr];
      rd_st1 <= st1_mem[addr];
      rd_st2 <= st2_mem[addr];
    end
    if (cmd.execute) begin
      if (iw.mode == OP_ALLOC) begin
        ids_mem[rd_addr] <= {iw.scen_tag, iw.evt_tag};
        st0_mem[rd_addr] <= {iw.stamp_b, iw.stamp_a};
        st1_mem[rd_addr] <= '0;
        st2_mem[rd_addr] <= '0;
      end else if (iw.mode == OP_SET12 && slot_ok) begin
        st1_mem[rd_addr] <= {iw.stamp_b, iw.stamp_a};
      end else if (iw.mode == OP_SET3 && slot_ok) begin
        st2_mem[rd_addr] <= {rd_st2[63:32], iw.stamp_a};
      end else if (iw.mode == OP_CLOSE && slot_ok) begin
        st2_mem[rd_addr] <= {iw.stamp_a, rd_st2[31:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) flags[i] <= '0;
      for (int i = 0; i < NUM_CNT; i++) counters[i] <= '0;
      total_allocated <= '0;
    end else if (cmd.execute) begin
      case (iw.mode) inside
        OP_ALLOC: begin
          if (total_allocated >= 32'(RING_DEPTH))
            counters[CNT_OVF] <= counters[CNT_OVF] + 32'd1;
          total_allocated <= total_allocated + 32'd1;
          flags[rd_addr] <= {1'b1, 4'b0, ST_PENDING};
        end
        OP_SET12, OP_SET3, OP_CLOSE, OP_DRISR, OP_DRTX, OP_TXERR, OP_TMO: begin
          if (!slot_ok) begin
            counters[CNT_MIS] <= counters[CNT_MIS] + 32'd1;
          end else begin
            case (iw.mode)
              OP_SET12: flags[rd_addr] <= f | 8'h18;
              OP_SET3: flags[rd_addr] <= f | 8'h20;
              OP_CLOSE: begin
                counters[CNT_SUCC] <= counters[CNT_SUCC] + 32'd1;
                if (dt <= deadline_ticks) begin
                  flags[rd_addr] <= {f[7] , f[6:3] | 4'b1000, ST_OK};
                end else begin
                  flags[rd_addr] <= {f[7], f[6:3] | 4'b1000, ST_LATE};
                  counters[CNT_LATE] <= counters[CNT_LATE] + 32'd1;
                end
              end
              OP_TXERR: flags[rd_addr] <= {f[7:3], ST_TXERR};
              OP_TMO: flags[rd_addr] <= {f[7:3], ST_TIMEOUT};
              default: flags[rd_addr] <= {f[7:3], ST_DROP};
            endcase
            if (iw.mode >= OP_DRISR)
              counters[iw.mode] <= counters[iw.mode] + 32'd1;
          end
        end
        OP_CRC, OP_TDROP, OP_TFAIL: counters[iw.mode] <= counters[iw.mode] + 32'd1;
        OP_RESET: begin
          for (int i = 0; i < RING_DEPTH; i++) flags[i] <= '0;
          for (int i = 0; i < NUM_CNT; i++) counters[i] <= '0;
          total_allocated <= '0;
        end
        default: ;
      endcase
    end
  end

  // Result formed from pre-update state, registered at execute
  out_word_t res;

  always_comb begin
    res = '0;
    case (iw.mode)
      OP_ALLOC: res.value = 32'(rd_addr);
      OP_READ: if (iw.counter_select < 4'(NUM_CNT))
        res.value = counters[iw.counter_select];
      OP_DUMP: begin
        res.value = 32'(iw.cursor);
        if (32'(iw.cursor) < count) begin
          res.value = 32'(iw.cursor) + 32'd1;
          res.found = f[7];
          res.rec_evt_tag = rd_ids[15:0];
          res.rec_scen_tag = rd_ids[23:16];
          res.rec_t0 = rd_st0[31:0];
          res.rec_abs_ms = rd_st0[63:32];
          res.rec_t1 = rd_st1[31:0];
          res.rec_t2 = rd_st1[63:32];
          res.rec_t3 = rd_st2[31:0];
          res.rec_t4 = rd_st2[63:32];
          res.rec_status = f[2:0];
          res.rec_stamp_mask = f[6:3];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) out_word <= res;
  end
endmodule

@@ hdl/event_latency_record_ring.sv @@
// Top level of the event latency record ring.
// Depends on elrr_pkg, elrr_ctrl and elrr_dpath.
//
// Usage: one operation word enters on the s_axis channel, and exactly one
// result word leaves on m_axis for every operation. The mode field picks
// alloc, stamp updates, closes, drops, counter increments, counter read,
// dump or a soft clear. The user must write deadline_ticks (cfg_we/cfg_wdata)
// only while idle, not enforced by the block; a close with (t4 - t0) above it is marked late.
//
// Sequence: a word accepted on s_axis is loaded by the controller, which
// issues the memory reads, and is then executed; its result is registered
// at execute. A new word is taken only when the controller is back in idle,
// after the load/execute sequence of the controller (one memory read, one
// read-modify-write per word). The result sits in its own output register,
// so the next word is accepted while it waits; if the receiver stalls, that
// next word holds in execute and s_axis_tready stays low until the result
// is taken.
//
// Reset (rst, synchronous): clears valid bits, counters, the allocation
// total and sets deadline_ticks to 20000. Record contents stay undefined.
module event_latency_record_ring (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[3:0], slot_index[19:4], evt_tag[35:20], scen_tag[43:36],
  // stamp_a[75:44], stamp_b[107:76], cursor[123:108], counter_select[127:124]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // value[31:0], found[32], rec_evt_tag[48:33], rec_scen_tag[56:49],
  // rec_t0[88:57], rec_t1[120:89], rec_t2[152:121], rec_t3[184:153],
  // rec_t4[216:185], rec_abs_ms[248:217], rec_status[251:249],
  // rec_stamp_mask[255:252]
  output logic [255:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  import elrr_pkg::*;

  dp_cmd_t   cmd;
  in_word_t  iw;
  out_word_t ow;
  logic [31:0] deadline_ticks;

  // Deadline register
  always_ff @(posedge clk) begin
    if (rst) deadline_ticks <= 32'd20000;
    else if (cfg_we) deadline_ticks <= cfg_wdata;
  end

  // Unpack the input word, lowest field first
  assign iw.mode = s_axis_tdata[3:0];
  assign iw.slot_index = s_axis_tdata[19:4];
  assign iw.evt_tag = s_axis_tdata[35:20];
  assign iw.scen_tag = s_axis_tdata[43:36];
  assign iw.stamp_a = s_axis_tdata[75:44];
  assign iw.stamp_b = s_axis_tdata[107:76];
  assign iw.cursor = s_axis_tdata[123:108];
  assign iw.counter_select = s_axis_tdata[127:124];

  // Pack the result word
  assign m_axis_tdata = {ow.rec_stamp_mask, ow.rec_status, ow.rec_abs_ms, ow.rec_t4,
                         ow.rec_t3, ow.rec_t2, ow.rec_t1, ow.rec_t0, ow.rec_scen_tag,
                         ow.rec_evt_tag, ow.found, ow.value};

  elrr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd)
  );

  elrr_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(iw),
    .deadline_ticks(deadline_ticks), .out_word(ow)
  );
endmodule
